// ===== design/mi3_pkg.sv =====
// Shared widths, types and constants of the 3x3 matrix inverse pipeline.
// No dependencies; every other file of the block imports this package.
package mi3_pkg;

  localparam int ELEMENT_BITS = 16;
  localparam int FRAC_BITS    = ELEMENT_BITS / 2;
  localparam int OUT_FRAC     = 16;
  localparam int DIM          = 3;
  localparam int NELEM        = DIM * DIM;
  localparam int OUT_BITS     = 32;
  // Quotient bits kept: one above the output word to see overflow.
  localparam int QB           = OUT_BITS + 1;

  localparam int PW  = 2 * ELEMENT_BITS;          // element product
  localparam int CW  = 2 * ELEMENT_BITS + 1;      // cofactor
  localparam int DPW = ELEMENT_BITS + CW;         // determinant term
  localparam int DW  = DPW + 2;                   // determinant
  localparam int SH  = FRAC_BITS + OUT_FRAC + 1;  // numerator shift
  localparam int NRAW = (2 * ELEMENT_BITS + SH > DW) ? (2 * ELEMENT_BITS + SH) : DW;
  localparam int NW  = NRAW + 1;                  // numerator
  localparam int RW  = DW + 2;                    // partial remainder

  typedef logic signed [ELEMENT_BITS-1:0] elem_t;
  typedef logic signed [PW-1:0]           prod_t;
  typedef logic signed [CW-1:0]           cof_t;
  typedef logic signed [DPW-1:0]          dprod_t;
  typedef logic signed [DW-1:0]           det_t;
  typedef logic [DW-1:0]                  mag_t;
  typedef logic [PW-1:0]                  cmag_t;
  typedef logic [DW:0]                    den_t;
  typedef logic [NW-1:0]                  num_t;
  typedef logic [RW-1:0]                  rem_t;
  typedef logic [QB-1:0]                  quo_t;
  typedef logic signed [OUT_BITS-1:0]     out_t;

  localparam out_t SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam out_t SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // Control that travels with every matrix through the pipeline.
  typedef struct packed {
    logic vld;
    logic sing;
  } ctl_t;

  // Wraps a row or column index that may run one or two past the edge.
  function automatic int wrap3(input int v);
    int r;
    r = v;
    if (r >= DIM) r = r - DIM;
    if (r >= DIM) r = r - DIM;
    return r;
  endfunction

endpackage

// ===== design/mi3_if.sv =====
// Valid/ready channel interfaces for matrix beats in and inverse beats out.
// Depends on mi3_pkg for the element and result types.
interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic valid;
  logic ready;
  out_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic singular;
  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, output ready);
endinterface

// ===== design/matrix_inverse_3x3_core.sv =====
// 3x3 matrix inverse by the adjugate: nine signed Q8.8 elements in, nine
// saturated signed Q16.16 elements and a singular flag out. The core is a
// 40-stage pipeline that takes one matrix beat every cycle while it is not
// held and gives one result beat per matrix: five stages of products,
// cofactors and determinant, one stage that forms the rounded numerator,
// 33 stages of a restoring divider that yields one quotient bit per stage in
// each of nine lanes, and the output register. The whole pipeline advances
// together; it holds while a result beat waits at the output and the sink is
// not ready, and it accepts a new beat whenever the output register is empty
// or being drained in the same cycle. Depends on mi3_pkg, mi3_if,
// mi3_front and mi3_divider.
module matrix_inverse_3x3_core (
  input  logic       clk,
  input  logic       rst_n,
  mi3_in_if.sink     in_bus,
  mi3_out_if.source  out_bus
);
  import mi3_pkg::*;

  logic   en;
  logic   out_v_r;
  elem_t  m_in [NELEM];

  ctl_t   f_ctl;
  mag_t   f_dmag;
  cmag_t  f_cmag [NELEM];
  logic   f_neg  [NELEM];

  ctl_t   d_ctl;
  quo_t   d_q   [NELEM];
  logic   d_ovf [NELEM];
  logic   d_neg [NELEM];

  out_t   res_nxt [NELEM];
  out_t   res_r   [NELEM];
  logic   sing_r;

  // Every register stage moves when the output slot is free or is being taken.
  assign en           = !out_v_r || out_bus.ready;
  assign in_bus.ready = en;

  assign m_in[0] = in_bus.a00;
  assign m_in[1] = in_bus.a01;
  assign m_in[2] = in_bus.a02;
  assign m_in[3] = in_bus.a10;
  assign m_in[4] = in_bus.a11;
  assign m_in[5] = in_bus.a12;
  assign m_in[6] = in_bus.a20;
  assign m_in[7] = in_bus.a21;
  assign m_in[8] = in_bus.a22;

  mi3_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_bus.valid),
    .m_i    (m_in),
    .ctl_o  (f_ctl),
    .dmag_o (f_dmag),
    .cmag_o (f_cmag),
    .neg_o  (f_neg)
  );

  mi3_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (f_ctl),
    .dmag_i (f_dmag),
    .cmag_i (f_cmag),
    .neg_i  (f_neg),
    .ctl_o  (d_ctl),
    .q_o    (d_q),
    .ovf_o  (d_ovf),
    .neg_o  (d_neg)
  );

  // Sign and saturation. A singular matrix forces every element to zero; the
  // divider output is meaningless then because the denominator is zero.
  always_comb begin
    for (int l = 0; l < NELEM; l++) begin
      if (d_ctl.sing) begin
        res_nxt[l] = '0;
      end else if (d_neg[l]) begin
        if (d_ovf[l] || d_q[l][QB-1] ||
            (d_q[l][OUT_BITS-1] && (|d_q[l][OUT_BITS-2:0]))) begin
          res_nxt[l] = SAT_NEG;
        end else begin
          res_nxt[l] = out_t'(OUT_BITS'(0) - d_q[l][OUT_BITS-1:0]);
        end
      end else begin
        if (d_ovf[l] || d_q[l][QB-1] || d_q[l][OUT_BITS-1]) begin
          res_nxt[l] = SAT_POS;
        end else begin
          res_nxt[l] = out_t'(d_q[l][OUT_BITS-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      sing_r <= d_ctl.sing;
    end
  end

  assign out_bus.valid    = out_v_r;
  assign out_bus.inv00    = res_r[0];
  assign out_bus.inv01    = res_r[1];
  assign out_bus.inv02    = res_r[2];
  assign out_bus.inv10    = res_r[3];
  assign out_bus.inv11    = res_r[4];
  assign out_bus.inv12    = res_r[5];
  assign out_bus.inv20    = res_r[6];
  assign out_bus.inv21    = res_r[7];
  assign out_bus.inv22    = res_r[8];
  assign out_bus.singular = sing_r;

endmodule

// ===== design/mi3_front.sv =====
// Front end: element products, adjugate cofactors, determinant and magnitudes.
// Five register stages. Depends on mi3_pkg.
module mi3_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  mi3_pkg::elem_t  m_i [mi3_pkg::NELEM],
  output mi3_pkg::ctl_t   ctl_o,
  output mi3_pkg::mag_t   dmag_o,
  output mi3_pkg::cmag_t  cmag_o [mi3_pkg::NELEM],
  output logic            neg_o [mi3_pkg::NELEM]
);
  import mi3_pkg::*;

  logic   v1_r, v2_r, v3_r, v4_r, v5_r;
  prod_t  pa_r [NELEM], pa_nxt [NELEM];
  prod_t  pb_r [NELEM], pb_nxt [NELEM];
  elem_t  m0a_r [DIM], m0b_r [DIM];
  cof_t   cof_r [NELEM], cof_nxt [NELEM];
  cof_t   cof2_r [NELEM], cof3_r [NELEM];
  dprod_t dp_r [DIM], dp_nxt [DIM];
  det_t   det_r, det_nxt;
  mag_t   dmag_r;
  cmag_t  cmag_r [NELEM];
  logic   neg_r [NELEM];
  logic   sing_r;

  // Cofactor of transposed position (j,i) lands at output slot i*3+j.
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        pa_nxt[i*DIM+j] = prod_t'(m_i[wrap3(j+1)*DIM + wrap3(i+1)])
                        * prod_t'(m_i[wrap3(j+2)*DIM + wrap3(i+2)]);
        pb_nxt[i*DIM+j] = prod_t'(m_i[wrap3(j+1)*DIM + wrap3(i+2)])
                        * prod_t'(m_i[wrap3(j+2)*DIM + wrap3(i+1)]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NELEM; k++) begin
      cof_nxt[k] = cof_t'(pa_r[k]) - cof_t'(pb_r[k]);
    end
  end

  // Expansion along row 0 uses the cofactors with j = 0.
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      dp_nxt[i] = dprod_t'(m0b_r[i]) * dprod_t'(cof_r[i*DIM]);
    end
  end

  assign det_nxt = det_t'(dp_r[0]) + det_t'(dp_r[1]) + det_t'(dp_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NELEM; k++) begin
        pa_r[k]   <= pa_nxt[k];
        pb_r[k]   <= pb_nxt[k];
        cof_r[k]  <= cof_nxt[k];
        cof2_r[k] <= cof_r[k];
        cof3_r[k] <= cof2_r[k];
        cmag_r[k] <= cof3_r[k][CW-1] ? cmag_t'(-cof3_r[k]) : cmag_t'(cof3_r[k]);
        neg_r[k]  <= cof3_r[k][CW-1] ^ det_r[DW-1];
      end
      for (int i = 0; i < DIM; i++) begin
        m0a_r[i] <= m_i[i];
        m0b_r[i] <= m0a_r[i];
        dp_r[i]  <= dp_nxt[i];
      end
      det_r  <= det_nxt;
      dmag_r <= det_r[DW-1] ? mag_t'(-det_r) : mag_t'(det_r);
      sing_r <= (det_r == '0);
    end
  end

  assign ctl_o.vld  = v5_r;
  assign ctl_o.sing = sing_r;
  assign dmag_o     = dmag_r;
  assign cmag_o     = cmag_r;
  assign neg_o      = neg_r;

endmodule

// ===== design/mi3_divider.sv =====
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Forms the rounded numerator, flags overflow, then runs QB steps. Uses mi3_pkg.
module mi3_divider (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  mi3_pkg::ctl_t   ctl_i,
  input  mi3_pkg::mag_t   dmag_i,
  input  mi3_pkg::cmag_t  cmag_i [mi3_pkg::NELEM],
  input  logic            neg_i [mi3_pkg::NELEM],
  output mi3_pkg::ctl_t   ctl_o,
  output mi3_pkg::quo_t   q_o [mi3_pkg::NELEM],
  output logic            ovf_o [mi3_pkg::NELEM],
  output logic            neg_o [mi3_pkg::NELEM]
);
  import mi3_pkg::*;

  ctl_t  ctl_r [QB+1];
  den_t  den_r [QB+1];
  rem_t  rem_r [QB+1][NELEM];
  quo_t  nlo_r [QB+1][NELEM];
  quo_t  q_r   [QB+1][NELEM];
  logic  ovf_r [QB+1][NELEM];
  logic  neg_r [QB+1][NELEM];

  den_t  den0;
  rem_t  rem0 [NELEM];
  quo_t  nlo0 [NELEM];
  logic  ovf0 [NELEM];

  // Numerator 2|C|*2^(FRAC+16) + |D| over denominator 2|D|. With the high part
  // below the denominator the quotient fits in QB bits.
  always_comb begin
    num_t num;
    num_t hi;
    den0 = {dmag_i, 1'b0};
    for (int l = 0; l < NELEM; l++) begin
      num     = (num_t'(cmag_i[l]) << SH) + num_t'(dmag_i);
      hi      = num >> QB;
      ovf0[l] = (hi >= num_t'(den0));
      rem0[l] = ovf0[l] ? '0 : rem_t'(hi);
      nlo0[l] = num[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den0;
      for (int l = 0; l < NELEM; l++) begin
        rem_r[0][l] <= rem0[l];
        nlo_r[0][l] <= nlo0[l];
        q_r[0][l]   <= '0;
        ovf_r[0][l] <= ovf0[l];
        neg_r[0][l] <= neg_i[l];
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    rem_t rem_nxt [NELEM];
    quo_t q_nxt   [NELEM];

    always_comb begin
      rem_t r2;
      for (int l = 0; l < NELEM; l++) begin
        r2 = {rem_r[s][l][RW-2:0], nlo_r[s][l][QB-1]};
        if (r2 >= rem_t'(den_r[s])) begin
          rem_nxt[l] = r2 - rem_t'(den_r[s]);
          q_nxt[l]   = {q_r[s][l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[l] = r2;
          q_nxt[l]   = {q_r[s][l][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1] <= '0;
      end else if (en) begin
        ctl_r[s+1] <= ctl_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s+1] <= den_r[s];
        for (int l = 0; l < NELEM; l++) begin
          rem_r[s+1][l] <= rem_nxt[l];
          nlo_r[s+1][l] <= {nlo_r[s][l][QB-2:0], 1'b0};
          q_r[s+1][l]   <= q_nxt[l];
          ovf_r[s+1][l] <= ovf_r[s][l];
          neg_r[s+1][l] <= neg_r[s][l];
        end
      end
    end
  end

  assign ctl_o = ctl_r[QB];
  assign q_o   = q_r[QB];
  assign ovf_o = ovf_r[QB];
  assign neg_o = neg_r[QB];

endmodule

// ===== tb/mi3_tb_if.sv =====
// Testbench constants shared by the testbench files of the matrix inverse core.
// Depends on mi3_pkg.
`timescale 1ns / 100ps
package mi3_tb_pkg;
  import mi3_pkg::*;
  localparam int TB_LATENCY = 40;
endpackage

// ===== tb/tb_matrix_inverse_3x3_core.sv =====
// Testbench for the 3x3 matrix inverse core: directed and random matrices,
// a scoreboard that predicts the adjugate inverse. Depends on mi3_pkg, mi3_if.
`timescale 1ns / 100ps
module tb_matrix_inverse_3x3_core;
  import mi3_pkg::*;
  import mi3_tb_pkg::*;

  // One expected inverse beat: nine Q16.16 elements and the singular flag.
  typedef struct {
    out_t inv[9];
    logic sing;
  } inverse_t;

  // Scoreboard: predicts an inverse per accepted matrix and checks results.
  class inverse_board;
    inverse_t pending[$];
    int errors;
    int checked;

    // Exact adjugate inverse, rounded to nearest with ties away from zero.
    function void note_matrix(elem_t a[9]);
      inverse_t e;
      longint signed m[3][3];
      longint signed det, cof, dmag, cmag;
      logic [127:0] num, q;
      logic neg;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) m[r][c] = a[r*3+c];
      det = 0;
      for (int i = 0; i < 3; i++)
        det += m[0][i] * (m[1][(i+1)%3] * m[2][(i+2)%3]
                        - m[1][(i+2)%3] * m[2][(i+1)%3]);
      e.sing = (det == 0);
      dmag = det < 0 ? -det : det;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (e.sing) begin
            e.inv[i*3+j] = '0;
            continue;
          end
          cof = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
              - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
          neg = (cof < 0) != (det < 0);
          cmag = cof < 0 ? -cof : cof;
          num = (128'(cmag) << (FRAC_BITS + OUT_FRAC + 1)) + 128'(dmag);
          q = num / (128'(dmag) << 1);
          if (neg) e.inv[i*3+j] = (q > 128'h80000000) ? SAT_NEG : out_t'(-q);
          else e.inv[i*3+j] = (q > 128'h7FFFFFFF) ? SAT_POS : out_t'(q);
        end
      pending.push_back(e);
    endfunction

    function void check_inverse(out_t got[9], logic sing);
      inverse_t e;
      checked++;
      if (pending.size() == 0) begin
        report("result beat with no matrix outstanding");
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 9; k++)
        if (got[k] !== e.inv[k])
          report($sformatf("inv%0d%0d got %h want %h", k/3, k%3, got[k], e.inv[k]));
      if (sing !== e.sing)
        report($sformatf("singular got %b want %b", sing, e.sing));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mi3_in_if  in_bus ();
  mi3_out_if out_bus ();

  matrix_inverse_3x3_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  inverse_board board = new();
  longint cycles = 0;
  int sent = 0;
  int singulars = 0;
  int stall_mode = 0;

  // Receiver: accepts results and checks them; ready follows a pattern that
  // changes mode now and then, including long stretches of full readiness.
  always @(posedge clk) begin
    out_t got[9];
    cycles <= cycles + 1;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.inv00, out_bus.inv01, out_bus.inv02, out_bus.inv10,
              out_bus.inv11, out_bus.inv12, out_bus.inv20, out_bus.inv21,
              out_bus.inv22};
      if (out_bus.singular) singulars++;
      board.check_inverse(got, out_bus.singular);
    end
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        2: out_bus.ready <= (cycles % 7 < 3);
        default: out_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Sends one matrix beat, holding it until the core accepts it.
  task automatic send_matrix(input elem_t a[9]);
    in_bus.valid <= 1'b1;
    {in_bus.a00, in_bus.a01, in_bus.a02} <= {a[0], a[1], a[2]};
    {in_bus.a10, in_bus.a11, in_bus.a12} <= {a[3], a[4], a[5]};
    {in_bus.a20, in_bus.a21, in_bus.a22} <= {a[6], a[7], a[8]};
    do @(posedge clk); while (!in_bus.ready);
    board.note_matrix(a);
    sent++;
  endtask

  task automatic idle_cycles(input int n);
    in_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random element: full range, small values, or extremes.
  function automatic elem_t pick_elem();
    case ($urandom_range(0, 5))
      0, 1: return elem_t'($urandom);
      2: return elem_t'($signed($urandom_range(0, 1024)) - 512);
      3: return elem_t'($signed($urandom_range(0, 16)) - 8);
      4: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return elem_t'($signed($urandom_range(0, 4)) - 2) <<< 8;
    endcase
  endfunction

  function automatic void random_matrix(output elem_t a[9]);
    int k;
    for (int i = 0; i < 9; i++) a[i] = pick_elem();
    // Sometimes force singularity: copy a row or column, or zero a row.
    case ($urandom_range(0, 9))
      0: begin
        k = $urandom_range(0, 1);
        for (int c = 0; c < 3; c++) a[6+c] = a[3*k+c];
      end
      1: for (int r = 0; r < 3; r++) a[r*3+2] = a[r*3];
      2: for (int c = 0; c < 3; c++) a[3+c] = '0;
      default: ;
    endcase
  endfunction

  initial begin : stimulus
    elem_t a[9];
    int burst;
    // Inputs start known; the sender updates them only at rising edges.
    in_bus.valid = 1'b0;
    {in_bus.a00, in_bus.a01, in_bus.a02, in_bus.a10, in_bus.a11,
     in_bus.a12, in_bus.a20, in_bus.a21, in_bus.a22} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, a diagonal, all zero, all extremes, a permutation, tiny,
    // signed and extreme diagonals, a rank-deficient, a banded and a dense matrix.
    a = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100}; send_matrix(a);
    a = '{16'sh0200, 0, 0, 0, -16'sh0080, 0, 0, 0, 16'sh0040}; send_matrix(a);
    a = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(a);
    for (int i = 0; i < 9; i++) a[i] = 16'sh7FFF; send_matrix(a);
    for (int i = 0; i < 9; i++) a[i] = 16'sh8000; send_matrix(a);
    a = '{0, 16'sh0100, 0, 0, 0, 16'sh0100, 16'sh0100, 0, 0}; send_matrix(a);
    a = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a);
    a = '{-1, 0, 0, 0, 1, 0, 0, 0, -1}; send_matrix(a);
    a = '{16'sh7FFF, 16'sh8000, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, 16'sh7FFF};
    send_matrix(a);
    a = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_matrix(a);
    a = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF}; send_matrix(a);
    a = '{1, 2, 3, 4, 5, 6, 7, 8, 9}; send_matrix(a);
    a = '{3, 0, 0, 0, 3, 0, 0, 0, 3}; send_matrix(a);
    a = '{2, 1, 0, 1, 2, 1, 0, 1, 2}; send_matrix(a);
    a = '{16'sh5555, -16'sh2AAA, 16'sh1234, -16'sh4321, 16'sh7001, 16'sh0F0F,
          16'sh00FF, -16'sh7F00, 16'sh3C3C}; send_matrix(a);

    // Random bursts with random gaps, some runs back to back.
    while (sent < 2000) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        random_matrix(a);
        send_matrix(a);
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    in_bus.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (TB_LATENCY + 10) @(posedge clk);
    $display("Sent %0d matrices (directed extremes, singular and random),",
             sent);
    $display("checked %0d inverse beats (%0d singular) under sender gaps and sink stalls.",
             board.checked, singulars);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Generous limit: every item waiting out heavy sink stalls plus latency.
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end
endmodule

// ===== matrix_inverse_3x3_core.f =====
design/mi3_pkg.sv
design/mi3_if.sv
design/mi3_front.sv
design/mi3_divider.sv
design/matrix_inverse_3x3_core.sv
tb/mi3_tb_if.sv
tb/tb_matrix_inverse_3x3_core.sv
